/* rtl/abe_pkg.sv */
// ----------------------------------------------------------------------------
// abe_pkg
// Types, codes and helpers shared by the add/branch execute block and its
// channel interfaces.
// ----------------------------------------------------------------------------
package abe_pkg;

	localparam int unsigned XLEN = 32;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_ADC = 3'd1,
		OP_B   = 3'd2,
		OP_BL  = 3'd3,
		OP_BLX = 3'd4,
		OP_BX  = 3'd5
	} op_t;

	typedef enum logic [3:0] {
		CC_EQ = 4'd0,
		CC_NE = 4'd1,
		CC_HS = 4'd2,
		CC_LO = 4'd3,
		CC_MI = 4'd4,
		CC_PL = 4'd5,
		CC_VS = 4'd6,
		CC_VC = 4'd7,
		CC_HI = 4'd8,
		CC_LS = 4'd9,
		CC_GE = 4'd10,
		CC_LT = 4'd11,
		CC_GT = 4'd12,
		CC_LE = 4'd13,
		CC_AL = 4'd14
	} cond_t;

	// flag positions inside nzcv
	localparam int unsigned FLAG_N = 3;
	localparam int unsigned FLAG_Z = 2;
	localparam int unsigned FLAG_C = 1;
	localparam int unsigned FLAG_V = 0;

	localparam logic [XLEN-1:0] PC_OFS_ARM   = 32'd8;
	localparam logic [XLEN-1:0] PC_OFS_THUMB = 32'd4;

	typedef struct packed {
		logic [2:0]      operation;
		logic [3:0]      condition;
		logic            set_flags;
		logic [XLEN-1:0] operand_a;
		logic [XLEN-1:0] operand_b;
		logic            first_is_pc;
		logic            second_is_pc;
		logic            dest_is_pc;
		logic            target_is_immediate;
		logic [XLEN-1:0] inst_address;
		logic [2:0]      inst_size;
	} in_item_t;

	typedef struct packed {
		logic [XLEN-1:0] dest_value;
		logic            dest_write;
		logic [XLEN-1:0] link_value;
		logic            link_write;
		logic [XLEN-1:0] next_pc;
		logic            condition_passed;
		logic [3:0]      flags_out;
		logic            thumb_out;
	} out_item_t;

	function automatic logic cond_holds(input logic [3:0] c, input logic [3:0] f);
		logic n;
		logic z;
		logic cy;
		logic v;
		logic r;
		n  = f[FLAG_N];
		z  = f[FLAG_Z];
		cy = f[FLAG_C];
		v  = f[FLAG_V];
		case (c)
			CC_EQ:   r = z;
			CC_NE:   r = !z;
			CC_HS:   r = cy;
			CC_LO:   r = !cy;
			CC_MI:   r = n;
			CC_PL:   r = !n;
			CC_VS:   r = v;
			CC_VC:   r = !v;
			CC_HI:   r = cy && !z;
			CC_LS:   r = !cy || z;
			CC_GE:   r = (n == v);
			CC_LT:   r = (n != v);
			CC_GT:   r = !z && (n == v);
			CC_LE:   r = z || (n != v);
			default: r = 1'b1;
		endcase
		return r;
	endfunction

endpackage

/* rtl/abe_in_if.sv */
// ----------------------------------------------------------------------------
// abe_in_if
// Valid/ready channel carrying one instruction to the execute block.
// ----------------------------------------------------------------------------
interface abe_in_if;
	logic              valid;
	logic              ready;
	abe_pkg::in_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/abe_out_if.sv */
// ----------------------------------------------------------------------------
// abe_out_if
// Valid/ready channel carrying one execute result.
// ----------------------------------------------------------------------------
interface abe_out_if;
	logic               valid;
	logic               ready;
	abe_pkg::out_item_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

/* rtl/arm32_add_branch_execute.sv */
// ----------------------------------------------------------------------------
// arm32_add_branch_execute
// Conditional ADD/ADC/B/BL/BLX/BX execute stage with NZCV flags and
// ARM/Thumb mode kept in the block.
// ----------------------------------------------------------------------------
//  channel  dir  payload     transfer
//  req      in   in_item_t   req.valid & req.ready
//  rsp      out  out_item_t  rsp.valid & rsp.ready
//
//  an instruction is held in the input register and is executed as it moves
//  to the result register; one instruction per cycle sustained while rsp is
//  not stalled. flags and mode update on that same move, so the next
//  instruction sees them. a stalled result holds both stages; req.ready is low
//  only while both registers are full and rsp is stalled. reset clears flags,
//  mode (ARM) and both valid bits.
module arm32_add_branch_execute (
	input  logic      clk,
	input  logic      arst_n,
	abe_in_if.sink    req,
	abe_out_if.source rsp
);

	logic                   valid_s1;
	abe_pkg::in_item_t      item_s1;
	logic                   valid_s2;
	abe_pkg::out_item_t     res_s2;
	logic [3:0]             nzcv_q;
	logic                   thumb_q;

	logic                   adv_s1;
	abe_pkg::out_item_t     res;
	logic [3:0]             nzcv_nxt;
	logic                   thumb_nxt;

	logic                   passed;
	logic [abe_pkg::XLEN-1:0] seq;
	logic [abe_pkg::XLEN-1:0] pcv;
	logic [abe_pkg::XLEN-1:0] x;
	logic [abe_pkg::XLEN-1:0] y;
	logic [abe_pkg::XLEN-1:0] sum;
	logic [abe_pkg::XLEN-1:0] dval;
	logic [abe_pkg::XLEN-1:0] t;
	logic                   is_adc;

	assign adv_s1    = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || adv_s1;
	assign rsp.valid = valid_s2;
	assign rsp.data  = res_s2;

	always_comb begin
		is_adc = (item_s1.operation == abe_pkg::OP_ADC);
		seq    = item_s1.inst_address + {{(abe_pkg::XLEN-3){1'b0}}, item_s1.inst_size};
		pcv    = item_s1.inst_address + (thumb_q ? abe_pkg::PC_OFS_THUMB : abe_pkg::PC_OFS_ARM);
		x      = (is_adc && item_s1.first_is_pc) ? pcv : item_s1.operand_a;
		y      = (is_adc && item_s1.second_is_pc) ? pcv : item_s1.operand_b;
		sum    = x + y + {{(abe_pkg::XLEN-1){1'b0}}, is_adc & nzcv_q[abe_pkg::FLAG_C]};
		dval   = (is_adc && item_s1.dest_is_pc) ? {sum[abe_pkg::XLEN-1:1], 1'b0} : sum;
		t      = x ^ y;
		passed = (item_s1.operation <= abe_pkg::OP_BX)
			&& abe_pkg::cond_holds(item_s1.condition, nzcv_q);
	end

	always_comb begin
		nzcv_nxt  = nzcv_q;
		thumb_nxt = thumb_q;
		res       = '0;
		res.next_pc          = seq;
		res.condition_passed = passed;
		if (passed) begin
			case (item_s1.operation)
				abe_pkg::OP_ADD, abe_pkg::OP_ADC: begin
					res.dest_value = dval;
					res.dest_write = 1'b1;
					if (is_adc && item_s1.dest_is_pc) begin
						thumb_nxt = sum[0];
					end
					if (item_s1.set_flags) begin
						nzcv_nxt[abe_pkg::FLAG_N] = dval[abe_pkg::XLEN-1];
						nzcv_nxt[abe_pkg::FLAG_Z] = (dval == '0);
						nzcv_nxt[abe_pkg::FLAG_C] = (x[abe_pkg::XLEN-1] & y[abe_pkg::XLEN-1])
							^ ((t[abe_pkg::XLEN-1] ^ dval[abe_pkg::XLEN-1]) & t[abe_pkg::XLEN-1]);
						nzcv_nxt[abe_pkg::FLAG_V] = (x[abe_pkg::XLEN-1] ^ ~y[abe_pkg::XLEN-1])
							& (x[abe_pkg::XLEN-1] ^ dval[abe_pkg::XLEN-1]);
					end else if (item_s1.dest_is_pc) begin
						res.next_pc = dval;
					end
				end
				abe_pkg::OP_B: begin
					res.next_pc = item_s1.operand_a;
				end
				abe_pkg::OP_BL: begin
					res.next_pc    = {item_s1.operand_a[abe_pkg::XLEN-1:1], 1'b0};
					res.link_value = seq | {{(abe_pkg::XLEN-1){1'b0}}, thumb_q};
					res.link_write = 1'b1;
				end
				abe_pkg::OP_BLX: begin
					res.next_pc    = {item_s1.operand_a[abe_pkg::XLEN-1:1], 1'b0};
					res.link_value = seq | {{(abe_pkg::XLEN-1){1'b0}}, thumb_q};
					res.link_write = 1'b1;
					// immediate form toggles, register form takes target bit 0
					thumb_nxt = item_s1.target_is_immediate ? !thumb_q : item_s1.operand_a[0];
				end
				abe_pkg::OP_BX: begin
					res.next_pc = {item_s1.operand_a[abe_pkg::XLEN-1:1], 1'b0};
					thumb_nxt   = item_s1.operand_a[0];
				end
				default: begin
					res.next_pc = seq;
				end
			endcase
		end
		res.flags_out = nzcv_nxt;
		res.thumb_out = thumb_nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			nzcv_q   <= '0;
			thumb_q  <= 1'b0;
		end else begin
			if (req.ready) begin
				valid_s1 <= req.valid;
			end
			if (adv_s1) begin
				valid_s2 <= 1'b1;
				nzcv_q   <= nzcv_nxt;
				thumb_q  <= thumb_nxt;
			end else if (rsp.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			item_s1 <= req.data;
		end
		if (adv_s1) begin
			res_s2 <= res;
		end
	end

endmodule
